### rtl/mglcm_pkg.sv
// ----------------------------------------------------------------------------
// mglcm_pkg
// Shared constants, types and helper functions of the masked horizontal
// gray-level co-occurrence matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package mglcm_pkg;

    localparam int MAX_LEVELS     = 8;
    localparam int COUNT_BITS     = 20;
    localparam int LEVEL_BITS     = $clog2(MAX_LEVELS);
    localparam int NBINS          = MAX_LEVELS * MAX_LEVELS;
    localparam int BIN_IDX_BITS   = $clog2(NBINS);
    localparam int LV_BITS        = 4;
    localparam int PIXEL_BITS     = 18;
    localparam int FRAC_BITS      = 16;
    localparam int PROB_BITS      = FRAC_BITS + 1;
    localparam int NUM_BITS       = COUNT_BITS + PROB_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_LEVELS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_USE_MASK   = 1'b1;

    localparam logic [LV_BITS-1:0]    LEVELS_RESET = LV_BITS'(MAX_LEVELS);
    localparam logic [LV_BITS-1:0]    LEVELS_MIN   = LV_BITS'(2);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [PROB_BITS-1:0]  PROB_ONE     = PROB_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic                    upd;
        logic [BIN_IDX_BITS-1:0] idx;
        logic                    emit;
        logic                    inv;
        logic [LV_BITS-1:0]      lv;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_RUN,
        BK_FLUSH,
        BK_READ,
        BK_LOAD,
        BK_DIV,
        BK_PUT
    } back_state_t;

    function automatic logic [LV_BITS-1:0] eff_levels(input logic [LV_BITS-1:0] l);
        logic [LV_BITS-1:0] r;
        r = l;
        if (l < LEVELS_MIN) begin
            r = LEVELS_MIN;
        end else if (l > LEVELS_RESET) begin
            r = LEVELS_RESET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mglcm_ram.sv
// ----------------------------------------------------------------------------
// mglcm_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/mglcm_fifo.sv
// ----------------------------------------------------------------------------
// mglcm_fifo
// Short command queue between the pixel front end and the histogram back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mglcm_pkg::cmd_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output mglcm_pkg::cmd_t      pop_data,
    output logic                 empty
);
    import mglcm_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;

    assign full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/mglcm_front.sv
// ----------------------------------------------------------------------------
// mglcm_front
// Accepts pixels, quantizes them, tracks the left neighbor of each row and
// turns pixels into histogram updates and/or emission requests.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic [mglcm_pkg::LV_BITS-1:0]          lv,
    input  wire logic                                   use_mask,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [mglcm_pkg::PIXEL_BITS-1:0] s_pixel,
    input  wire logic                                   s_in_mask,
    input  wire logic                                   s_row_last,
    input  wire logic                                   s_image_last,
    input  wire logic                                   q_full,
    output logic                                        q_push,
    output mglcm_pkg::cmd_t                             q_data
);
    import mglcm_pkg::*;

    logic [LEVEL_BITS-1:0]           prev_level_reg;
    logic                            prev_valid_reg;
    logic                            inv_seen_reg;
    logic                            accept;
    logic                            pix_ok;
    logic                            usable;
    logic [FRAC_BITS+LV_BITS-1:0]    prod;
    logic [LV_BITS-1:0]              lv_m1;
    logic [LEVEL_BITS-1:0]           level;
    logic [BIN_IDX_BITS:0]           idx_sum;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Valid pixels lie in [0, 1.0]; 1.0 itself maps to the top level.
    assign pix_ok  = !s_pixel[PIXEL_BITS-1]
                     && (!s_pixel[FRAC_BITS] || (s_pixel[FRAC_BITS-1:0] == '0));
    assign prod    = s_pixel[FRAC_BITS-1:0] * lv;
    assign lv_m1   = lv - 1'b1;
    assign level   = s_pixel[FRAC_BITS] ? lv_m1[LEVEL_BITS-1:0]
                                        : prod[FRAC_BITS +: LEVEL_BITS];
    assign usable  = pix_ok && (!use_mask || s_in_mask);
    assign idx_sum = (BIN_IDX_BITS+1)'(level) * (BIN_IDX_BITS+1)'(lv)
                     + (BIN_IDX_BITS+1)'(prev_level_reg);

    always_comb begin
        q_data.upd  = usable && prev_valid_reg;
        q_data.idx  = idx_sum[BIN_IDX_BITS-1:0];
        q_data.emit = s_image_last;
        q_data.inv  = inv_seen_reg || !pix_ok;
        q_data.lv   = lv;
        q_push      = accept && (q_data.upd || q_data.emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= '0;
            prev_valid_reg <= 1'b0;
            inv_seen_reg   <= 1'b0;
        end else if (accept) begin
            prev_valid_reg <= usable && !s_row_last && !s_image_last;
            if (s_image_last) begin
                prev_level_reg <= '0;
                inv_seen_reg   <= 1'b0;
            end else begin
                if (usable) begin
                    prev_level_reg <= level;
                end
                if (!pix_ok) begin
                    inv_seen_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/mglcm_div.sv
// ----------------------------------------------------------------------------
// mglcm_div
// Radix-2 restoring divider computing round(bin * 2^16 / total), one quotient
// bit per cycle. The quotient is held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [mglcm_pkg::COUNT_BITS-1:0] bin,
    input  wire logic [mglcm_pkg::COUNT_BITS-1:0] total,
    output logic                                  done,
    output logic      [mglcm_pkg::PROB_BITS-1:0]  quotient
);
    import mglcm_pkg::*;

    localparam int CNT_BITS = $clog2(PROB_BITS);

    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [PROB_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [NUM_BITS-1:0]   num;
    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    assign num      = {1'b0, bin, FRAC_BITS'(0)} + NUM_BITS'(total >> 1);
    assign shifted  = {rem_reg, quo_reg[PROB_BITS-1]};
    assign ge       = (shifted >= {1'b0, div_reg});
    assign diff     = shifted - {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(PROB_BITS - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_BITS-1:PROB_BITS];
            quo_reg <= num[PROB_BITS-1:0];
            div_reg <= total;
        end else if (run_reg) begin
            rem_reg <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[PROB_BITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

### rtl/mglcm_back.sv
// ----------------------------------------------------------------------------
// mglcm_back
// Executes queued histogram updates as a two-stage read-modify-write on the
// bin RAM, and on an emission request sweeps the bins, normalizes each one
// and presents it on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_empty,
    input  wire mglcm_pkg::cmd_t                    q_data,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [mglcm_pkg::PROB_BITS-1:0]    m_probability,
    output logic      [mglcm_pkg::LEVEL_BITS-1:0]   m_first_level,
    output logic      [mglcm_pkg::LEVEL_BITS-1:0]   m_second_level,
    output logic      [mglcm_pkg::COUNT_BITS-1:0]   m_bin_count,
    output logic                                    m_had_invalid,
    output logic                                    m_no_pairs,
    output logic                                    m_last_entry
);
    import mglcm_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic                    b_valid_reg;
    logic [BIN_IDX_BITS-1:0] b_idx_reg;
    logic                    fwd_valid_reg;
    logic [BIN_IDX_BITS-1:0] fwd_idx_reg;
    logic [COUNT_BITS-1:0]   fwd_data_reg;
    logic [NBINS-1:0]        hist_valid_reg;
    logic [COUNT_BITS-1:0]   total_reg;
    logic [LV_BITS-1:0]      lv_reg;
    logic                    inv_reg;
    logic [BIN_IDX_BITS-1:0] e_reg;
    logic [LEVEL_BITS-1:0]   col_reg;
    logic [LEVEL_BITS-1:0]   row_reg;
    logic [COUNT_BITS-1:0]   bin_reg;
    logic                    m_valid_reg;

    logic [BIN_IDX_BITS-1:0] rd_addr;
    logic [COUNT_BITS-1:0]   rd_data;
    logic [COUNT_BITS-1:0]   old_count;
    logic [COUNT_BITS-1:0]   new_count;
    logic [COUNT_BITS-1:0]   load_bin;
    logic [LV_BITS-1:0]      lv_m1;
    logic                    entry_last;
    logic                    total_zero;
    logic                    div_start;
    logic                    div_done;
    logic [PROB_BITS-1:0]    div_quo;
    logic [PROB_BITS-1:0]    prob;
    logic                    put;

    mglcm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NBINS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_idx_reg),
        .wr_data (new_count),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mglcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .bin      (load_bin),
        .total    (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // A bin that was written in the previous cycle is forwarded, since the
    // RAM returned its old contents.
    always_comb begin
        if (fwd_valid_reg && (fwd_idx_reg == b_idx_reg)) begin
            old_count = fwd_data_reg;
        end else if (hist_valid_reg[b_idx_reg]) begin
            old_count = rd_data;
        end else begin
            old_count = '0;
        end
        new_count = (old_count == COUNT_MAX) ? COUNT_MAX : old_count + 1'b1;
    end

    assign load_bin   = hist_valid_reg[e_reg] ? rd_data : '0;
    assign lv_m1      = lv_reg - 1'b1;
    assign entry_last = (col_reg == lv_m1[LEVEL_BITS-1:0])
                        && (row_reg == lv_m1[LEVEL_BITS-1:0]);
    assign total_zero = (total_reg == '0);
    assign prob       = total_zero ? '0 : ((div_quo > PROB_ONE) ? PROB_ONE : div_quo);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN: begin
                if (!q_empty && q_data.emit) begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                state_next = BK_READ;
            end
            BK_READ: begin
                state_next = BK_LOAD;
            end
            BK_LOAD: begin
                state_next = total_zero ? BK_PUT : BK_DIV;
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_PUT;
                end
            end
            BK_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = entry_last ? BK_RUN : BK_READ;
                end
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        rd_addr   = q_data.idx;
        div_start = 1'b0;
        put       = 1'b0;
        case (state_reg)
            BK_RUN: begin
                q_pop = !q_empty;
            end
            BK_READ: begin
                rd_addr = e_reg;
            end
            BK_LOAD: begin
                div_start = !total_zero;
            end
            BK_PUT: begin
                put = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_RUN;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            hist_valid_reg <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            b_valid_reg   <= q_pop && q_data.upd;
            fwd_valid_reg <= b_valid_reg;
            if (put && entry_last) begin
                hist_valid_reg <= '0;
                total_reg      <= '0;
            end else if (b_valid_reg) begin
                hist_valid_reg[b_idx_reg] <= 1'b1;
                if (total_reg != COUNT_MAX) begin
                    total_reg <= total_reg + 1'b1;
                end
            end
            if (put) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_idx_reg    <= q_data.idx;
        fwd_idx_reg  <= b_idx_reg;
        fwd_data_reg <= new_count;
        if (q_pop && q_data.emit) begin
            lv_reg  <= q_data.lv;
            inv_reg <= q_data.inv;
            e_reg   <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        if (state_reg == BK_LOAD) begin
            bin_reg <= load_bin;
        end
        if (put) begin
            m_probability  <= prob;
            m_first_level  <= col_reg;
            m_second_level <= row_reg;
            m_bin_count    <= bin_reg;
            m_had_invalid  <= inv_reg;
            m_no_pairs     <= total_zero;
            m_last_entry   <= entry_last;
            e_reg          <= e_reg + 1'b1;
            if (col_reg == lv_m1[LEVEL_BITS-1:0]) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/masked_glcm_horizontal.sv
// ----------------------------------------------------------------------------
// masked_glcm_horizontal
// Streaming gray-level co-occurrence matrix over horizontally adjacent pixel
// pairs, with optional masking, emitted as normalized entries at image end.
//
//   Channel  Ports               Moves
//   input    s_valid / s_ready   one pixel request with mask and row markers
//   result   m_valid / m_ready   one matrix entry request per level pair
//   config   cfg_wr_en           register write, no handshake
//
// Pixels are taken one per cycle unless the queue is full; a four-entry
// command queue separates the quantizer from the two-stage bin update
// pipeline on the bin RAM. At image end a flush state is followed, for each
// of the L*L entries, by a RAM read, a load, the 17-step divider and an
// output state; the divider is skipped when no pair was counted.
// Pixels keep entering the queue during emission until it fills.
// Reset clears the bin valid flags at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_glcm_horizontal (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [mglcm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [mglcm_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [mglcm_pkg::PIXEL_BITS-1:0] s_pixel,
    input  wire logic                                    s_in_mask,
    input  wire logic                                    s_row_last,
    input  wire logic                                    s_image_last,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic      [mglcm_pkg::PROB_BITS-1:0]         m_probability,
    output logic      [mglcm_pkg::LEVEL_BITS-1:0]        m_first_level,
    output logic      [mglcm_pkg::LEVEL_BITS-1:0]        m_second_level,
    output logic      [mglcm_pkg::COUNT_BITS-1:0]        m_bin_count,
    output logic                                         m_had_invalid,
    output logic                                         m_no_pairs,
    output logic                                         m_last_entry
);
    import mglcm_pkg::*;

    logic [LV_BITS-1:0] num_levels_reg;
    logic               use_mask_reg;
    logic [LV_BITS-1:0] lv;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    cmd_t               push_cmd;
    cmd_t               pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_levels_reg <= LEVELS_RESET;
            use_mask_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NUM_LEVELS: begin
                    num_levels_reg <= cfg_wdata[LV_BITS-1:0];
                end
                REG_USE_MASK: begin
                    use_mask_reg <= cfg_wdata[0];
                end
                default: begin
                    use_mask_reg <= use_mask_reg;
                end
            endcase
        end
    end

    assign lv = eff_levels(num_levels_reg);

    mglcm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lv           (lv),
        .use_mask     (use_mask_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_in_mask    (s_in_mask),
        .s_row_last   (s_row_last),
        .s_image_last (s_image_last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_cmd)
    );

    mglcm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    mglcm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_data         (pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_probability  (m_probability),
        .m_first_level  (m_first_level),
        .m_second_level (m_second_level),
        .m_bin_count    (m_bin_count),
        .m_had_invalid  (m_had_invalid),
        .m_no_pairs     (m_no_pairs),
        .m_last_entry   (m_last_entry)
    );

endmodule

`default_nettype wire

### rtl/mglcm_checker.sv
// ----------------------------------------------------------------------------
// mglcm_checker
// Port-level checks on the result channel of the co-occurrence block.
// ----------------------------------------------------------------------------
`default_nettype none

module mglcm_checker (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    m_valid,
    input  wire logic                                    m_ready,
    input  wire logic [mglcm_pkg::PROB_BITS-1:0]         m_probability,
    input  wire logic [mglcm_pkg::LEVEL_BITS-1:0]        m_first_level,
    input  wire logic [mglcm_pkg::LEVEL_BITS-1:0]        m_second_level,
    input  wire logic                                    m_no_pairs,
    input  wire logic                                    m_last_entry
);
    import mglcm_pkg::*;

    // The result channel comes out of reset empty.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result request valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_probability))
        else $error("stalled result request changed");

    // An empty image must report zero probability everywhere.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_pairs |-> m_probability == '0)
        else $error("nonzero probability with no pairs");

    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_probability[PROB_BITS-1] |-> m_probability[PROB_BITS-2:0] == '0)
        else $error("probability above one");

    // The final entry of a matrix sits on its diagonal corner.
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_entry |-> m_first_level == m_second_level)
        else $error("last entry is not the corner of the matrix");

endmodule

bind masked_glcm_horizontal mglcm_checker u_checker (.*);

`default_nettype wire

### bench/masked_glcm_horizontal_tb.sv
// ----------------------------------------------------------------------------
// masked_glcm_horizontal_tb
// Self-checking bench for the masked horizontal co-occurrence matrix block.
// Pixel requests are fed from a queue by a clocked driver with random gaps.
// A predictor inside the bench follows every accepted pixel and queues the
// matrix entries that an image end must produce. A clocked monitor compares
// each accepted result with the oldest queued entry under random back pressure.
// A directed part covers level edges, invalid pixels, masking, an empty image,
// out-of-range level counts and a level change in the middle of an image.
// Random images with random sizes and settings follow.
// ----------------------------------------------------------------------------
module masked_glcm_horizontal_tb;

    import mglcm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 100;
    localparam int RANDOM_ITEMS  = 180;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic                         in_mask;
        logic                         row_last;
        logic                         image_last;
    } pixel_req_t;

    typedef struct {
        logic [PROB_BITS-1:0]  probability;
        logic [LEVEL_BITS-1:0] first_level;
        logic [LEVEL_BITS-1:0] second_level;
        logic [COUNT_BITS-1:0] bin_count;
        logic                  had_invalid;
        logic                  no_pairs;
        logic                  last_entry;
    } glcm_entry_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_wdata    = '0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic signed [PIXEL_BITS-1:0] s_pixel      = '0;
    logic                         s_in_mask    = 1'b0;
    logic                         s_row_last   = 1'b0;
    logic                         s_image_last = 1'b0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [PROB_BITS-1:0]         m_probability;
    logic [LEVEL_BITS-1:0]        m_first_level;
    logic [LEVEL_BITS-1:0]        m_second_level;
    logic [COUNT_BITS-1:0]        m_bin_count;
    logic                         m_had_invalid;
    logic                         m_no_pairs;
    logic                         m_last_entry;

    pixel_req_t  pixel_pending_q[$];
    glcm_entry_t entry_expect_q[$];

    int unsigned pair_hist[NBINS];
    int unsigned pair_sum;
    logic [LEVEL_BITS-1:0] prev_level;
    bit          prev_ok;
    bit          bad_seen;
    logic [CFG_DATA_BITS-1:0] cfg_levels;
    bit          cfg_mask;

    bit pix_fire    = 1'b0;
    int mismatches  = 0;
    int items_queued = 0;
    int s_gap_pct   = 0;
    int m_stall_pct = 0;
    int gap_left    = 0;
    int stall_left  = 0;

    masked_glcm_horizontal u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_in_mask     (s_in_mask),
        .s_row_last    (s_row_last),
        .s_image_last  (s_image_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_probability (m_probability),
        .m_first_level (m_first_level),
        .m_second_level(m_second_level),
        .m_bin_count   (m_bin_count),
        .m_had_invalid (m_had_invalid),
        .m_no_pairs    (m_no_pairs),
        .m_last_entry  (m_last_entry)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_image_state();
        foreach (pair_hist[i]) begin
            pair_hist[i] = 0;
        end
        pair_sum   = 0;
        prev_level = '0;
        prev_ok    = 1'b0;
        bad_seen   = 1'b0;
    endfunction

    // Follows one accepted pixel request and queues the matrix entries that
    // an image end releases.
    task automatic predict_pixel(input pixel_req_t px);
        int unsigned lv;
        int unsigned raw;
        int unsigned lvl;
        int unsigned idx;
        bit          ok;
        bit          usable;
        longint unsigned prob;
        glcm_entry_t e;
        lv  = (cfg_levels < 2) ? 2 : ((cfg_levels > MAX_LEVELS) ? MAX_LEVELS : cfg_levels);
        raw = {14'd0, px.pixel};
        ok  = !px.pixel[PIXEL_BITS-1] && raw <= 65536;
        lvl = 0;
        if (!ok) begin
            bad_seen = 1'b1;
        end else if (raw == 65536) begin
            lvl = lv - 1;
        end else begin
            lvl = (raw * lv) >> FRAC_BITS;
        end
        usable = ok && (!cfg_mask || px.in_mask);
        if (usable && prev_ok) begin
            idx = (prev_level + lvl * lv) % NBINS;
            if (pair_hist[idx] < COUNT_MAX) begin
                pair_hist[idx]++;
            end
            if (pair_sum < COUNT_MAX) begin
                pair_sum++;
            end
        end
        prev_ok = usable && !px.row_last && !px.image_last;
        if (usable) begin
            prev_level = lvl[LEVEL_BITS-1:0];
        end
        if (px.image_last) begin
            for (int i = 0; i < lv * lv; i++) begin
                prob = 0;
                if (pair_sum != 0) begin
                    prob = (longint'(pair_hist[i]) * 65536 + pair_sum / 2) / pair_sum;
                end
                if (prob > 65536) begin
                    prob = 65536;
                end
                e.probability  = prob[PROB_BITS-1:0];
                e.first_level  = LEVEL_BITS'(i % lv);
                e.second_level = LEVEL_BITS'(i / lv);
                e.bin_count    = pair_hist[i][COUNT_BITS-1:0];
                e.had_invalid  = bad_seen;
                e.no_pairs     = (pair_sum == 0);
                e.last_entry   = (i == lv * lv - 1);
                entry_expect_q.push_back(e);
            end
            clear_image_state();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : glcm_monitor
        pixel_req_t  px;
        glcm_entry_t want;
        pix_fire = aresetn && s_valid && s_ready;
        if (pix_fire) begin
            px.pixel      = s_pixel;
            px.in_mask    = s_in_mask;
            px.row_last   = s_row_last;
            px.image_last = s_image_last;
            predict_pixel(px);
        end
        if (aresetn && m_valid && m_ready) begin
            if (entry_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $error("unexpected matrix entry: first_level %0d, second_level %0d",
                           m_first_level, m_second_level);
                end
            end else begin
                want = entry_expect_q.pop_front();
                check_field("probability", want.probability, m_probability);
                check_field("first_level", want.first_level, m_first_level);
                check_field("second_level", want.second_level, m_second_level);
                check_field("bin_count", want.bin_count, m_bin_count);
                check_field("had_invalid", want.had_invalid, m_had_invalid);
                check_field("no_pairs", want.no_pairs, m_no_pairs);
                check_field("last_entry", want.last_entry, m_last_entry);
            end
        end
    end

    always @(negedge aclk) begin : pixel_driver
        pixel_req_t px;
        if (aresetn && !(s_valid && !pix_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (s_gap_pct != 0 && $urandom_range(0, 99) < s_gap_pct) begin
                gap_left = $urandom_range(0, 13);
                s_valid <= 1'b0;
            end else if (pixel_pending_q.size() != 0) begin
                px = pixel_pending_q.pop_front();
                s_pixel      <= px.pixel;
                s_in_mask    <= px.in_mask;
                s_row_last   <= px.row_last;
                s_image_last <= px.image_last;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_acceptor
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (m_stall_pct != 0 && $urandom_range(0, 99) < m_stall_pct) begin
            stall_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_pixel(input logic signed [PIXEL_BITS-1:0] pixel, input bit in_mask,
                              input bit row_last, input bit image_last);
        pixel_req_t px;
        px.pixel      = pixel;
        px.in_mask    = in_mask;
        px.row_last   = row_last;
        px.image_last = image_last;
        pixel_pending_q.push_back(px);
        items_queued++;
    endtask

    function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
        int unsigned pick;
        int unsigned lv;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return PIXEL_BITS'($urandom);
        end
        if (pick < 15) begin
            return PIXEL_BITS'((pick < 12) ? 0 : ((pick < 14) ? 65536 : 65535));
        end
        if (pick < 35) begin
            lv = $urandom_range(2, MAX_LEVELS);
            k  = $urandom_range(1, lv - 1);
            return PIXEL_BITS'((k * 65536 + lv - 1) / lv - $urandom_range(0, 1));
        end
        return PIXEL_BITS'($urandom_range(0, 65536));
    endfunction

    task automatic add_image(input int rows, input int cols, input bit closed);
        bit rl;
        bit il;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                il = closed && r == rows - 1 && c == cols - 1;
                rl = (c == cols - 1);
                if ($urandom_range(0, 15) == 0) begin
                    rl = !rl;
                end
                push_pixel(random_pixel(), $urandom_range(0, 4) != 0, rl, il);
            end
        end
    endtask

    task automatic wait_quiet();
        do begin
            @(posedge aclk);
        end while (pixel_pending_q.size() != 0 || s_valid || entry_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_NUM_LEVELS) begin
            cfg_levels = value;
        end else begin
            cfg_mask = value[0];
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_BITS-1:0] level_plan[12];
        int  phase;
        bit  calm_tail;
        level_plan = '{4'd8, 4'd2, 4'd5, 4'd0, 4'd7, 4'd3, 4'd15, 4'd4, 4'd1, 4'd6, 4'd9, 4'd8};
        cfg_levels = LEVELS_RESET;
        cfg_mask   = 1'b0;
        clear_image_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_NUM_LEVELS, 4'd8);
        write_reg(REG_USE_MASK, 4'd0);
        s_gap_pct   = 20;
        m_stall_pct = 20;
        push_pixel(0, 1'b1, 1'b0, 1'b0);
        push_pixel(65536, 1'b0, 1'b0, 1'b0);
        push_pixel(65535, 1'b1, 1'b0, 1'b0);
        push_pixel(32768, 1'b1, 1'b0, 1'b0);
        push_pixel(8191, 1'b1, 1'b0, 1'b0);
        push_pixel(8192, 1'b1, 1'b1, 1'b0);
        push_pixel(65536, 1'b1, 1'b0, 1'b0);
        push_pixel(-1, 1'b1, 1'b0, 1'b0);
        push_pixel(65537, 1'b1, 1'b0, 1'b0);
        push_pixel(0, 1'b1, 1'b0, 1'b0);
        push_pixel(131071, 1'b1, 1'b0, 1'b0);
        push_pixel(-131072, 1'b1, 1'b0, 1'b0);
        push_pixel(16384, 1'b1, 1'b0, 1'b1);
        push_pixel(40000, 1'b1, 1'b1, 1'b1);

        // Level count below the minimum, with masking on.
        wait_quiet();
        write_reg(REG_NUM_LEVELS, 4'd0);
        write_reg(REG_USE_MASK, 4'd1);
        push_pixel(65536, 1'b1, 1'b0, 1'b0);
        push_pixel(30000, 1'b1, 1'b0, 1'b0);
        push_pixel(40000, 1'b0, 1'b0, 1'b0);
        push_pixel(50000, 1'b1, 1'b0, 1'b0);
        push_pixel(60000, 1'b1, 1'b1, 1'b0);
        push_pixel(65536, 1'b1, 1'b1, 1'b1);
        push_pixel(20000, 1'b1, 1'b0, 1'b0);
        push_pixel(50000, 1'b1, 1'b0, 1'b0);

        // The image above is still open: the level count changes under it.
        wait_quiet();
        write_reg(REG_NUM_LEVELS, 4'd15);
        write_reg(REG_USE_MASK, 4'd0);
        push_pixel(65536, 1'b0, 1'b0, 1'b0);
        push_pixel(10000, 1'b0, 1'b0, 1'b1);

        phase = 0;
        while (items_queued < RANDOM_ITEMS) begin
            calm_tail = (items_queued >= RANDOM_ITEMS - 80);
            wait_quiet();
            write_reg(REG_NUM_LEVELS, level_plan[phase % 12]);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_USE_MASK, CFG_DATA_BITS'($urandom_range(0, 1)));
            end
            s_gap_pct   = calm_tail ? 0 : 15 * $urandom_range(0, 3);
            m_stall_pct = calm_tail ? 0 : 15 * $urandom_range(0, 3);
            repeat ($urandom_range(1, 3)) begin
                add_image($urandom_range(1, 4), $urandom_range(1, 6), 1'b1);
            end
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
                add_image(1, $urandom_range(1, 4), 1'b0);
            end
            phase++;
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
